/* hdl/ccrl_pkg.sv */
`default_nettype none

package ccrl_pkg;

  // fixed field widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int FILT_W       = 32;

  // defaults for the top-level parameters
  localparam int PHASE_WIDTH_DEF    = 32;
  localparam int NCO_TABLE_BITS_DEF = 10;

  // configuration registers
  localparam int MODE_W     = 3;
  localparam int PGAIN_W    = 24;
  localparam int IGAIN_W    = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 2'd2;

  localparam logic [MODE_W-1:0]  LOOP_MODE_RST     = 3'd0;
  localparam logic [PGAIN_W-1:0] PHASE_GAIN_RST    = 24'd65536;
  localparam logic [IGAIN_W-1:0] INTEGRAL_GAIN_RST = 16'd1024;

  // error detector codes (anything else is the plain q detector)
  localparam logic [MODE_W-1:0] MODE_COSTAS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HARD   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QPSK   = 3'd3;

  // datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
  localparam logic [OP_W-1:0] OP_TRIG   = 5'd1;
  localparam logic [OP_W-1:0] OP_ROT0   = 5'd2;
  localparam logic [OP_W-1:0] OP_ROT1   = 5'd3;
  localparam logic [OP_W-1:0] OP_ROT2   = 5'd4;
  localparam logic [OP_W-1:0] OP_ROT3   = 5'd5;
  localparam logic [OP_W-1:0] OP_ROT4   = 5'd6;
  localparam logic [OP_W-1:0] OP_E_PASS = 5'd7;
  localparam logic [OP_W-1:0] OP_E_SIGN = 5'd8;
  localparam logic [OP_W-1:0] OP_E_IQ   = 5'd9;
  localparam logic [OP_W-1:0] OP_E_RND  = 5'd10;
  localparam logic [OP_W-1:0] OP_E_P    = 5'd11;
  localparam logic [OP_W-1:0] OP_E_SQ   = 5'd12;
  localparam logic [OP_W-1:0] OP_E_D    = 5'd13;
  localparam logic [OP_W-1:0] OP_E_PD   = 5'd14;
  localparam logic [OP_W-1:0] OP_G0     = 5'd15;
  localparam logic [OP_W-1:0] OP_G1     = 5'd16;
  localparam logic [OP_W-1:0] OP_I0     = 5'd17;
  localparam logic [OP_W-1:0] OP_I1     = 5'd18;
  localparam logic [OP_W-1:0] OP_I2     = 5'd19;
  localparam logic [OP_W-1:0] OP_F      = 5'd20;
  localparam logic [OP_W-1:0] OP_N      = 5'd21;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] in_i;
    logic signed [SAMPLE_WIDTH-1:0] in_q;
    logic                           restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_i;
    logic signed [SAMPLE_WIDTH-1:0] out_q;
    logic signed [FILT_W-1:0]       filter_out;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  loop_mode;
    logic [PGAIN_W-1:0] phase_gain;
    logic [IGAIN_W-1:0] integral_gain;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // odd polynomial for sin(pi/2 * x), Q30 coefficients
  localparam logic [63:0] SIN_A1 = 64'd1686629713;
  localparam logic [63:0] SIN_A3 = 64'd693598669;
  localparam logic [63:0] SIN_A5 = 64'd85569306;
  localparam logic [63:0] SIN_A7 = 64'd5026994;
  localparam logic [63:0] SIN_A9 = 64'd172273;

  // x is a Q30 fraction of a quarter turn; result Q1.15, saturated at +max
  function automatic logic [SAMPLE_WIDTH-1:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    s  = SIN_A7 - ((SIN_A9 * x2) >> 30);
    s  = SIN_A5 - ((s * x2) >> 30);
    s  = SIN_A3 - ((s * x2) >> 30);
    s  = SIN_A1 - ((s * x2) >> 30);
    s  = (s * x) >> 30;
    r  = (s + (64'd1 << (30 - SAMPLE_WIDTH))) >> (31 - SAMPLE_WIDTH);
    if (r > ((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1)) begin
      r = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/costas_carrier_recovery_loop_core.sv */
// costas / pll carrier recovery loop
// in channel: in_valid / in_stall with in_item (in_i, in_q Q1.15, restart); an item is
//   taken at a clock edge with in_valid high and in_stall low
// out channel: out_valid / out_stall with out_item (out_i, out_q Q1.15, filter_out); one
//   result per input item, in order
// config: cfg_write, cfg_index, cfg_data; index 0 loop_mode, 1 phase_gain,
//   2 integral_gain, index 3 is ignored; write only while no item is in flight
// latency: the result is loaded into the output register 14 cycles after the item is
//   taken with the q or hard-limited detector, 15 with the i*q detector and 19 with
//   the qpsk detector
// throughput: one item every 15, 16 or 20 cycles for those detectors; one shared
//   25x26 multiplier carries the rotation, the detector, the gain and the integral
//   steps in turn, and the next sample needs the phase that this one leaves
// the next item is taken while a finished result waits in the output register; a
//   stalled receiver holds the block only when a second result is ready to commit
// reset clears the nco phase, the loop filter state, the output valid and sets the
//   registers to mode 0, phase_gain 65536 and integral_gain 1024; a restart item clears
//   the loop state just before it is processed
`default_nettype none

module costas_carrier_recovery_loop_core #(
  parameter int PHASE_WIDTH    = ccrl_pkg::PHASE_WIDTH_DEF,
  parameter int NCO_TABLE_BITS = ccrl_pkg::NCO_TABLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input samples
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire ccrl_pkg::in_item_t                 in_item,
  // derotated samples and filter value
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output ccrl_pkg::out_item_t                     out_item,
  // register writes
  input  wire logic                               cfg_write,
  input  wire logic [ccrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ccrl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ccrl_pkg::cfg_t    cfg;
  ccrl_pkg::cmd_t    cmd;
  ccrl_pkg::status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode     <= ccrl_pkg::LOOP_MODE_RST;
      cfg.phase_gain    <= ccrl_pkg::PHASE_GAIN_RST;
      cfg.integral_gain <= ccrl_pkg::INTEGRAL_GAIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ccrl_pkg::CFG_LOOP_MODE:
          cfg.loop_mode <= cfg_data[ccrl_pkg::MODE_W-1:0];
        ccrl_pkg::CFG_PHASE_GAIN:
          cfg.phase_gain <= cfg_data[ccrl_pkg::PGAIN_W-1:0];
        ccrl_pkg::CFG_INTEGRAL_GAIN:
          cfg.integral_gain <= cfg_data[ccrl_pkg::IGAIN_W-1:0];
        default: ;  // unused index
      endcase
    end
  end

  // sequencer: one step of the sample's work per cycle; commit waits on a busy output
  ccrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .loop_mode (cfg.loop_mode),
    .status    (status),
    .cmd       (cmd)
  );

  // nco table, shared multiplier, loop filter state and output register
  ccrl_dp #(
    .PHASE_WIDTH    (PHASE_WIDTH),
    .NCO_TABLE_BITS (NCO_TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* hdl/ccrl_ctrl.sv */
`default_nettype none

module ccrl_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ccrl_pkg::MODE_W-1:0]    loop_mode,
  input  wire ccrl_pkg::status_t              status,
  output ccrl_pkg::cmd_t                      cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_TRIG = 5'd1;
  localparam logic [4:0] S_ROT0 = 5'd2;
  localparam logic [4:0] S_ROT1 = 5'd3;
  localparam logic [4:0] S_ROT2 = 5'd4;
  localparam logic [4:0] S_ROT3 = 5'd5;
  localparam logic [4:0] S_ROT4 = 5'd6;
  localparam logic [4:0] S_ERR  = 5'd7;
  localparam logic [4:0] S_ERND = 5'd8;
  localparam logic [4:0] S_EP   = 5'd9;
  localparam logic [4:0] S_ESQ  = 5'd10;
  localparam logic [4:0] S_ED   = 5'd11;
  localparam logic [4:0] S_EPD  = 5'd12;
  localparam logic [4:0] S_G0   = 5'd13;
  localparam logic [4:0] S_G1   = 5'd14;
  localparam logic [4:0] S_I0   = 5'd15;
  localparam logic [4:0] S_I1   = 5'd16;
  localparam logic [4:0] S_I2   = 5'd17;
  localparam logic [4:0] S_F    = 5'd18;
  localparam logic [4:0] S_N    = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TRIG;
        end
      end
      S_TRIG: begin cmd.op = ccrl_pkg::OP_TRIG; state_next = S_ROT0; end
      S_ROT0: begin cmd.op = ccrl_pkg::OP_ROT0; state_next = S_ROT1; end
      S_ROT1: begin cmd.op = ccrl_pkg::OP_ROT1; state_next = S_ROT2; end
      S_ROT2: begin cmd.op = ccrl_pkg::OP_ROT2; state_next = S_ROT3; end
      S_ROT3: begin cmd.op = ccrl_pkg::OP_ROT3; state_next = S_ROT4; end
      S_ROT4: begin cmd.op = ccrl_pkg::OP_ROT4; state_next = S_ERR;  end
      S_ERR: begin
        case (loop_mode)
          ccrl_pkg::MODE_COSTAS: begin
            cmd.op     = ccrl_pkg::OP_E_IQ;
            state_next = S_ERND;
          end
          ccrl_pkg::MODE_QPSK: begin
            cmd.op     = ccrl_pkg::OP_E_IQ;
            state_next = S_EP;
          end
          ccrl_pkg::MODE_HARD: begin
            cmd.op     = ccrl_pkg::OP_E_SIGN;
            state_next = S_G0;
          end
          default: begin
            cmd.op     = ccrl_pkg::OP_E_PASS;
            state_next = S_G0;
          end
        endcase
      end
      S_EP:   begin cmd.op = ccrl_pkg::OP_E_P;   state_next = S_ESQ;  end
      S_ESQ:  begin cmd.op = ccrl_pkg::OP_E_SQ;  state_next = S_ED;   end
      S_ED:   begin cmd.op = ccrl_pkg::OP_E_D;   state_next = S_EPD;  end
      S_EPD:  begin cmd.op = ccrl_pkg::OP_E_PD;  state_next = S_ERND; end
      S_ERND: begin cmd.op = ccrl_pkg::OP_E_RND; state_next = S_G0;   end
      S_G0:   begin cmd.op = ccrl_pkg::OP_G0;    state_next = S_G1;   end
      S_G1:   begin cmd.op = ccrl_pkg::OP_G1;    state_next = S_I0;   end
      S_I0:   begin cmd.op = ccrl_pkg::OP_I0;    state_next = S_I1;   end
      S_I1:   begin cmd.op = ccrl_pkg::OP_I1;    state_next = S_I2;   end
      S_I2:   begin cmd.op = ccrl_pkg::OP_I2;    state_next = S_F;    end
      S_F:    begin cmd.op = ccrl_pkg::OP_F;     state_next = S_N;    end
      S_N: begin
        // wait here while the output register still holds an untaken item
        if (!status.out_busy) begin
          cmd.op     = ccrl_pkg::OP_N;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ccrl_pkg::OP_N) |-> !status.out_busy)
    else $error("result committed over an untaken item");

  a_ready_after_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ccrl_pkg::OP_N) |=> !in_stall)
    else $error("not ready after result commit");

endmodule

`default_nettype wire

/* hdl/ccrl_dp.sv */
`default_nettype none

module ccrl_dp #(
  parameter int PHASE_WIDTH    = ccrl_pkg::PHASE_WIDTH_DEF,
  parameter int NCO_TABLE_BITS = ccrl_pkg::NCO_TABLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ccrl_pkg::cmd_t      cmd,
  output ccrl_pkg::status_t        status,
  input  wire ccrl_pkg::cfg_t      cfg,
  input  wire ccrl_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ccrl_pkg::out_item_t      out_item
);

  localparam int SW     = ccrl_pkg::SAMPLE_WIDTH;
  localparam int FW     = ccrl_pkg::FILT_W;
  localparam int FIN_W  = ccrl_pkg::PGAIN_W + 1;       // gain * error >> 15 fits here
  localparam int MA_W   = FIN_W;
  localparam int MB_W   = FIN_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ACC_W  = SUM_W - ccrl_pkg::IGAIN_W;
  localparam int QB     = NCO_TABLE_BITS - 2;
  localparam int QTR    = 1 << QB;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (SW - 2);
  localparam logic signed [SUM_W-1:0] IG_HALF  = SUM_W'(1) <<< (ccrl_pkg::IGAIN_W - 1);
  localparam logic signed [SUM_W-1:0] S_MAX    = (SUM_W'(1) <<< (SW - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] S_MIN    = -S_MAX - SUM_W'(1);
  localparam logic signed [ACC_W-1:0] F_MAX    = (ACC_W'(1) <<< (FW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] F_MIN    = -F_MAX - ACC_W'(1);
  localparam logic [QB:0]             QTR_IDX  = (QB + 1)'(QTR);

  function automatic logic signed [SUM_W-1:0] rnd(input logic signed [SUM_W-1:0] v);
    return (v + RND_HALF) >>> (SW - 1);
  endfunction

  function automatic logic signed [SW-1:0] sat_s(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > S_MAX) begin
      r = S_MAX;
    end else if (v < S_MIN) begin
      r = S_MIN;
    end
    return r[SW-1:0];
  endfunction

  function automatic logic signed [FW-1:0] sat_f(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > F_MAX) begin
      r = F_MAX;
    end else if (v < F_MIN) begin
      r = F_MIN;
    end
    return r[FW-1:0];
  endfunction

  // quarter-wave sine table, entries 0 .. QTR inclusive
  logic signed [SW-1:0] sine_tbl [0:QTR];

  for (genvar g = 0; g <= QTR; g++) begin : g_sine
    assign sine_tbl[g] = ccrl_pkg::quarter_sine(64'(g) << (30 - QB));
  end

  // loop state
  logic [PHASE_WIDTH-1:0]  nco;
  logic signed [FIN_W-1:0] prev_f_in;
  logic signed [FW-1:0]    integ;
  logic signed [FW-1:0]    prev_f_out;

  // working registers
  logic signed [SW-1:0]     xi;
  logic signed [SW-1:0]     xq;
  logic signed [SW-1:0]     sa;
  logic signed [SW-1:0]     sb;
  logic [1:0]               quad;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [SW-1:0]     oi;
  logic signed [SW-1:0]     oq;
  logic signed [SW:0]       pr;
  logic signed [SW:0]       dr;
  logic signed [SW-1:0]     err;
  logic signed [FIN_W-1:0]  f_in;
  logic signed [FIN_W:0]    fsum;
  logic signed [ACC_W-1:0]  half;
  logic signed [FW-1:0]     f_out;

  // combinational
  logic [QB:0]              x_a;
  logic [QB:0]              x_b;
  logic signed [SW-1:0]     cos_v;
  logic signed [SW-1:0]     sin_v;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     mul_en;
  logic                     acc_en;
  logic signed [SUM_W-1:0]  rnd_sum;
  logic signed [SUM_W-1:0]  rnd_diff;
  logic signed [SUM_W-1:0]  rnd_prod;
  logic signed [SUM_W-1:0]  neg_oq;
  logic signed [FIN_W-1:0]  fin_new;
  logic signed [SUM_W-1:0]  hsum;
  logic signed [FW:0]       nsum;

  assign x_a = {1'b0, nco[PHASE_WIDTH-3 -: QB]};
  assign x_b = QTR_IDX - x_a;

  always_comb begin
    case (quad)
      2'd0: begin sin_v = sa;  cos_v = sb;  end
      2'd1: begin sin_v = sb;  cos_v = -sa; end
      2'd2: begin sin_v = -sa; cos_v = -sb; end
      default: begin sin_v = -sb; cos_v = sa; end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    acc_en = 1'b0;
    case (cmd.op)
      ccrl_pkg::OP_ROT0: begin mul_a = MA_W'(xi); mul_b = MB_W'(cos_v); end
      ccrl_pkg::OP_ROT1: begin
        mul_a = MA_W'(xq); mul_b = MB_W'(sin_v); acc_en = 1'b1;
      end
      ccrl_pkg::OP_ROT2: begin mul_a = MA_W'(xq); mul_b = MB_W'(cos_v); end
      ccrl_pkg::OP_ROT3: begin
        mul_a = MA_W'(xi); mul_b = MB_W'(sin_v); acc_en = 1'b1;
      end
      ccrl_pkg::OP_E_IQ: begin mul_a = MA_W'(oi); mul_b = MB_W'(oq); end
      ccrl_pkg::OP_E_P:  begin mul_a = MA_W'(oi); mul_b = MB_W'(oi); end
      ccrl_pkg::OP_E_SQ: begin
        mul_a = MA_W'(oq); mul_b = MB_W'(oq); acc_en = 1'b1;
      end
      ccrl_pkg::OP_E_PD: begin mul_a = MA_W'(pr); mul_b = MB_W'(dr); end
      ccrl_pkg::OP_G0: begin
        mul_a = $signed({1'b0, cfg.phase_gain});
        mul_b = MB_W'(err);
      end
      ccrl_pkg::OP_I0: begin
        mul_a = MA_W'($signed({1'b0, cfg.integral_gain}));
        mul_b = fsum;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign rnd_sum  = rnd(SUM_W'(acc) + SUM_W'(prod));
  assign rnd_diff = rnd(SUM_W'(acc) - SUM_W'(prod));
  assign rnd_prod = rnd(SUM_W'(prod));
  assign neg_oq   = -(SUM_W'(oq));
  assign fin_new  = prod[FIN_W+SW-2 -: FIN_W];
  assign hsum     = SUM_W'(prod) + IG_HALF;
  assign nsum     = (FW + 1)'(f_out) + (FW + 1)'(prev_f_out);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (acc_en) begin
      acc <= prod;
    end
    if (cmd.load) begin
      xi <= in_item.in_i;
      xq <= in_item.in_q;
    end
    case (cmd.op)
      ccrl_pkg::OP_TRIG: begin
        sa   <= sine_tbl[x_a];
        sb   <= sine_tbl[x_b];
        quad <= nco[PHASE_WIDTH-1 -: 2];
      end
      ccrl_pkg::OP_ROT2:   oi  <= sat_s(rnd_sum);
      ccrl_pkg::OP_ROT4:   oq  <= sat_s(rnd_diff);
      ccrl_pkg::OP_E_PASS: err <= oq;
      ccrl_pkg::OP_E_SIGN: err <= oi[SW-1] ? sat_s(neg_oq) : oq;
      ccrl_pkg::OP_E_RND:  err <= sat_s(rnd_prod);
      ccrl_pkg::OP_E_P:    pr  <= rnd_prod[SW:0];
      ccrl_pkg::OP_E_D:    dr  <= rnd_diff[SW:0];
      ccrl_pkg::OP_G1: begin
        f_in <= fin_new;
        fsum <= (FIN_W + 1)'(fin_new) + (FIN_W + 1)'(prev_f_in);
      end
      ccrl_pkg::OP_I1: half  <= hsum[SUM_W-1 -: ACC_W];
      ccrl_pkg::OP_F:  f_out <= sat_f(ACC_W'(integ) + ACC_W'(f_in));
      ccrl_pkg::OP_N: begin
        out_item.out_i      <= oi;
        out_item.out_q      <= oq;
        out_item.filter_out <= f_out;
      end
      default: ;
    endcase
  end

  // loop state: cleared by reset and by a restart item
  always_ff @(posedge clk) begin
    if (rst || (cmd.load && in_item.restart)) begin
      nco        <= '0;
      prev_f_in  <= '0;
      integ      <= '0;
      prev_f_out <= '0;
    end else begin
      case (cmd.op)
        ccrl_pkg::OP_I2: integ <= sat_f(ACC_W'(integ) + half);
        ccrl_pkg::OP_N: begin
          nco        <= nco + nsum[PHASE_WIDTH:1];
          prev_f_in  <= f_in;
          prev_f_out <= f_out;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == ccrl_pkg::OP_N) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire
